>>> sv/mawu_pkg.sv
// package for the moving average window unit
// holds field widths, register map, sequencer states and window control struct
// no dependencies
`timescale 1ns / 1ps

package mawu_pkg;

   // default sizing, handed down through top-level parameters
   localparam int MAX_WINDOW_DEF  = 64;
   localparam int SAMPLE_BITS_DEF = 16;

   // fixed field widths
   localparam int SAMPLE_IN_WIDTH = 16;
   localparam int AVERAGE_WIDTH   = 16;

   // register map
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int LEN_REG_WIDTH   = 7;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_WINDOW_LENGTH_ADDR = 3'h0;
   localparam logic [LEN_REG_WIDTH-1:0]  LEN_RESET              = 7'd16;

   // item sequencer states
   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_UPDATE,
      SEQ_START,
      SEQ_DIVIDE
   } seq_state_type;

   // window control from the sequencer
   typedef struct packed {
      logic clear;   // drop all stored samples and the sum
      logic read;    // fetch the oldest sample at the write pointer
      logic commit;  // store the new sample, update sum and pointer
   } win_ctrl_type;

endpackage

>>> sv/mawu_ifs.sv
// valid/ready channel interfaces for the moving average window unit
// request carries one sample, response carries one average; uses mawu_pkg
`timescale 1ns / 1ps

interface mawu_req_if import mawu_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [SAMPLE_IN_WIDTH-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface mawu_rsp_if import mawu_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [AVERAGE_WIDTH-1:0] average;

   modport source (output valid, output average, input ready);
   modport sink   (input valid, input average, output ready);
endinterface

>>> sv/moving_average_window_unit.sv
// moving average window unit: boxcar average over the last window_length samples
// one item at a time: a new sample is accepted only once the previous average has gone into
// the result register; the average comes from a bit-serial divider that produces one quotient
// bit per cycle
// reset: synchronous, window_length 16, empty window (zeros), zero sum, no result pending
// depends on mawu_pkg, mawu_ifs, mawu_window, mawu_divider
`timescale 1ns / 1ps

module moving_average_window_unit import mawu_pkg::*; #(
   parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   mawu_req_if.sink                  req_bus,
   mawu_rsp_if.source                rsp_bus,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   localparam int LEN_BITS = $clog2(MAX_WINDOW+1);
   localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW);

   seq_state_type              state_ff, state_in;
   logic [LEN_REG_WIDTH-1:0]   len_reg_ff, len_reg_in;
   logic [LEN_BITS-1:0]        len_eff;
   logic                       csr_wr;
   logic [SAMPLE_BITS-1:0]     sample_ff, sample_in_q;
   logic [SAMPLE_BITS+SAMPLE_IN_WIDTH-1:0] sample_ext;
   logic                       req_accept;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [AVERAGE_WIDTH-1:0]   average_ff, average_in;
   logic                       slot_free;
   logic                       rsp_load;
   win_ctrl_type               win_ctrl;
   logic [SUM_BITS-1:0]        win_sum;
   logic                       div_start;
   logic                       div_busy;
   logic                       div_done;
   logic [SUM_BITS-1:0]        quotient;
   logic [SUM_BITS+AVERAGE_WIDTH-1:0] quo_ext;

   // configuration port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr == CSR_WINDOW_LENGTH_ADDR);
   assign prdata = (paddr == CSR_WINDOW_LENGTH_ADDR)
                   ? CSR_DATA_WIDTH'(len_reg_ff) : '0;
   assign len_reg_in = csr_wr ? pwdata[LEN_REG_WIDTH-1:0] : len_reg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_reg_ff <= LEN_RESET;
      end else begin
         len_reg_ff <= len_reg_in;
      end
   end

   // effective length: zero acts as one, oversized values clamp to the depth
   always_comb begin
      priority if (len_reg_ff == '0) begin
         len_eff = LEN_BITS'(1);
      end else if (32'(len_reg_ff) > 32'(MAX_WINDOW)) begin
         len_eff = LEN_BITS'(MAX_WINDOW);
      end else begin
         len_eff = LEN_BITS'(len_reg_ff);
      end
   end

   // incoming sample, only the low SAMPLE_BITS bits count
   assign sample_ext  = {{SAMPLE_BITS{1'b0}}, req_bus.sample_in};
   assign sample_in_q = sample_ext[SAMPLE_BITS-1:0];
   assign req_accept  = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_ff <= sample_in_q;
      end
   end

   // result register frees when empty or taken this cycle
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   // item sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      req_bus.ready   = 1'b0;
      win_ctrl.clear  = csr_wr;
      win_ctrl.read   = 1'b0;
      win_ctrl.commit = 1'b0;
      div_start       = 1'b0;
      rsp_load        = 1'b0;
      unique case (state_ff)
         SEQ_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               win_ctrl.read = 1'b1;
               state_in      = SEQ_UPDATE;
            end
         end
         SEQ_UPDATE: begin
            win_ctrl.commit = 1'b1;
            state_in        = SEQ_START;
         end
         SEQ_START: begin
            div_start = 1'b1;
            state_in  = SEQ_DIVIDE;
         end
         SEQ_DIVIDE: begin
            if (div_done && slot_free) begin
               rsp_load = 1'b1;
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // delay line and running sum
   mawu_window #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_window (
      .clock (clock),
      .reset (reset),
      .ctrl  (win_ctrl),
      .len   (len_eff),
      .fresh (sample_ff),
      .sum   (win_sum)
   );

   // sum divided by effective length
   mawu_divider #(
      .SUM_BITS (SUM_BITS),
      .LEN_BITS (LEN_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (win_sum),
      .divisor  (len_eff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   // result register, low bits of the quotient
   assign quo_ext = {{AVERAGE_WIDTH{1'b0}}, quotient};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      average_in   = average_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         average_in   = quo_ext[AVERAGE_WIDTH-1:0];
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      average_ff <= average_in;
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.average = average_ff;

   // a finished quotient with a free slot shows up as a result next cycle
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_DIVIDE && div_done && slot_free) |=> rsp_valid_ff)
      else $error("finished quotient not presented as a result");

   // a new item never arrives while the divider is still iterating
   a_accept_div_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> !div_busy)
      else $error("item accepted while divider busy");

   // while waiting on the divider it is either iterating or finished
   a_divide_progress: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_DIVIDE) |-> (div_busy || div_done))
      else $error("sequencer waiting on an idle divider");

endmodule

>>> sv/mawu_window.sv
// circular delay line with write pointer and running sum
// depends on mawu_pkg for the window control struct
`timescale 1ns / 1ps

module mawu_window import mawu_pkg::*; #(
   parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  win_ctrl_type                                      ctrl,
   input  logic [$clog2(MAX_WINDOW+1)-1:0]                   len,
   input  logic [SAMPLE_BITS-1:0]                            fresh,
   output logic [SAMPLE_BITS+$clog2(MAX_WINDOW)-1:0]         sum
);

   localparam int PTR_BITS = $clog2(MAX_WINDOW);
   localparam int LEN_BITS = $clog2(MAX_WINDOW+1);
   localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW);

   logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic [PTR_BITS-1:0]    wp_ff, wp_in;
   logic                   wrapped_ff, wrapped_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] oldest;
   logic [LEN_BITS-1:0]    wp_plus;

   // sample memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         mem[wp_ff] <= fresh;
      end
      if (ctrl.read) begin
         rd_data_ff <= mem[wp_ff];
      end
   end

   // slots are filled in order from zero, so before the first wrap the slot
   // at the pointer holds no sample of the window and counts as a zero sample
   assign oldest = wrapped_ff ? rd_data_ff : '0;

   // pointer advance modulo the window length
   assign wp_plus = LEN_BITS'(wp_ff) + LEN_BITS'(1);

   always_comb begin
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      sum_in     = sum_ff;
      if (ctrl.clear) begin
         wp_in      = '0;
         wrapped_in = 1'b0;
         sum_in     = '0;
      end else if (ctrl.commit) begin
         sum_in = sum_ff + SUM_BITS'(fresh) - SUM_BITS'(oldest);
         if (wp_plus >= len) begin
            wp_in      = '0;
            wrapped_in = 1'b1;
         end else begin
            wp_in = wp_plus[PTR_BITS-1:0];
         end
      end
   end

   // window state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
         sum_ff     <= '0;
      end else begin
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
         sum_ff     <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

>>> sv/mawu_divider.sv
// restoring shift-subtract divider, one quotient bit per cycle
// self-contained, uses mawu_pkg only for its default parameter sizes
`timescale 1ns / 1ps

module mawu_divider import mawu_pkg::*; #(
   parameter int SUM_BITS = SAMPLE_BITS_DEF + $clog2(MAX_WINDOW_DEF),
   parameter int LEN_BITS = $clog2(MAX_WINDOW_DEF+1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SUM_BITS-1:0] dividend,
   input  logic [LEN_BITS-1:0] divisor,
   output logic                busy,
   output logic                done,
   output logic [SUM_BITS-1:0] quotient
);

   localparam int CNT_BITS = $clog2(SUM_BITS+1);

   logic [LEN_BITS-1:0] rem_ff, rem_in;
   logic [SUM_BITS-1:0] quo_ff, quo_in;
   logic [LEN_BITS-1:0] dsr_ff, dsr_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [LEN_BITS:0]   shifted;
   logic [LEN_BITS:0]   diff;

   // shared trial subtract
   assign shifted = {rem_ff, quo_ff[SUM_BITS-1]};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the low bits hold it
         if (!diff[LEN_BITS]) begin
            rem_in = diff[LEN_BITS-1:0];
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[LEN_BITS-1:0];
            quo_in = {quo_ff[SUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(SUM_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
